>>> rtl/core/xsr_pkg.sv
// Package for the xorshift1024* range draw block: types and constants.
`default_nettype none
package xsr_pkg;

  localparam int WORD_W     = 64;
  localparam int BOUND_W    = 31;
  localparam int POOL_DEPTH = 16;
  localparam int POS_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int MUL_STEPS  = WORD_W / DIGIT_W;
  localparam int MUL_CNT_W  = 4;
  localparam int DIV_STEPS  = WORD_W;
  localparam int DIV_CNT_W  = 6;

  localparam int SHL_A = 31;
  localparam int SHR_B = 11;
  localparam int SHR_C = 30;

  localparam logic [WORD_W-1:0] GOLDEN_MUL = 64'h9e37_79b9_7f4a_7c13;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_SETPOS = 2'd1,
    FUNC_DRAW   = 2'd2
  } xsr_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } xsr_state_t;

endpackage
`default_nettype wire

>>> rtl/core/xsr_if.sv
// Valid/ready channel interfaces for the draw request and result words.
`default_nettype none
interface xsr_in_if;
  import xsr_pkg::*;
  logic                valid;
  logic                ready;
  xsr_func_t           func;
  logic [POS_W-1:0]    word_index;
  logic [WORD_W-1:0]   seed_word;
  logic [BOUND_W-1:0]  range_bound;

  modport source (output valid, func, word_index, seed_word, range_bound, input ready);
  modport sink   (input valid, func, word_index, seed_word, range_bound, output ready);
endinterface

interface xsr_out_if;
  import xsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   raw_word;
  logic [BOUND_W-1:0]  drawn_value;
  logic                bad_bound;

  modport source (output valid, raw_word, drawn_value, bad_bound, input ready);
  modport sink   (input valid, raw_word, drawn_value, bad_bound, output ready);
endinterface
`default_nettype wire

>>> rtl/core/xsr_div.sv
// Bit-serial restoring remainder unit: 64-bit dividend by 31-bit divisor.
`default_nettype none
module xsr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [xsr_pkg::WORD_W-1:0]    dividend,
  input  wire logic [xsr_pkg::BOUND_W-1:0]   divisor,
  output logic                               done,
  output logic [xsr_pkg::BOUND_W-1:0]        remainder
);
  import xsr_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    dvd_r;
  logic [BOUND_W-1:0]   dvs_r;
  logic [BOUND_W-1:0]   rem_r;
  logic [BOUND_W:0]     trial;
  logic [BOUND_W:0]     diff;
  logic [BOUND_W-1:0]   rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  assign trial   = {rem_r, dvd_r[WORD_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

>>> rtl/core/xorshift1024_star_range_draw.sv
// Top level: xorshift1024* generator with range reduction of each draw.
//
// Input channel in_ch carries one request word per handshake:
//   func 0 writes seed_word into pool[word_index], func 1 sets the
//   position to word_index, func 2 draws a number below range_bound.
//   func 3 is dropped. Writes and position sets do not leave idle.
// Output channel out_ch carries one result word per draw: the scrambled
//   64-bit raw_word, raw_word mod range_bound, and bad_bound when the
//   bound was zero (drawn_value then reads 0).
// A draw runs from accept to the result register through ST_MIX, which
//   mixes the two pool words, ST_MUL for the golden-ratio multiply
//   (one 4-bit digit per cycle), ST_DIV for the remainder unit (one
//   quotient bit per cycle) and its done flag, then ST_DONE for the
//   output load. The remainder loop sets the draw rate while the
//   receiver keeps up. in_ch.ready is high only while no draw is in
//   progress. A result held in the output register does not block new
//   requests; a finished draw waits for the output register to free up when the receiver stalls.
// Reset makes the pool read as zero, zeroes the position, drops any
//   pending result. Seed the pool with a nonzero word before drawing.
`default_nettype none
module xorshift1024_star_range_draw (
  input  wire logic   clk,
  input  wire logic   rst_n,
  xsr_in_if.sink      in_ch,
  xsr_out_if.source   out_ch
);
  import xsr_pkg::*;

  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);

  xsr_state_t state_r, state_nxt;

  logic                  in_fire;
  logic                  draw_acc;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_inc;

  logic [WORD_W-1:0]     pool_mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] pool_vld_r;
  logic                  wr_en;
  logic [POS_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;

  logic [WORD_W-1:0]     rd_old_r, rd_new_r;
  logic                  old_vld_r, new_vld_r;
  logic [WORD_W-1:0]     old_word, new_word, mix_t, mixed;

  logic [WORD_W-1:0]           mul_op_r;
  logic [WORD_W-1:0]           acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0]        mul_cnt_r;
  logic [WORD_W+DIGIT_W-1:0]   digit_prod;

  logic [BOUND_W-1:0]    bound_r;
  logic                  bad_r;

  logic                  div_start, div_done;
  logic [BOUND_W-1:0]    div_rem;

  logic                  mix_go, mul_run, out_load;
  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_raw_r;
  logic [BOUND_W-1:0]    out_val_r;
  logic                  out_bad_r;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign draw_acc = in_fire && (in_ch.func == FUNC_DRAW);
  assign pos_inc  = pos_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (draw_acc) state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_MUL;
      ST_MUL:  if (mul_cnt_r == MUL_LAST) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mix_go      = 1'b0;
    mul_run     = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_MIX:  mix_go = 1'b1;
      ST_MUL: begin
        mul_run   = 1'b1;
        div_start = (mul_cnt_r == MUL_LAST);
      end
      ST_DIV:  ;
      ST_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire && in_ch.func == FUNC_SETPOS) begin
      pos_r <= in_ch.word_index;
    end else if (draw_acc) begin
      pos_r <= pos_inc;
    end
  end

  // pool write port: seed writes from idle, mixed word back in MIX
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = mixed;
    priority if (mix_go) begin
      wr_en = 1'b1;
    end else if (in_fire && in_ch.func == FUNC_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = in_ch.word_index;
      wr_data = in_ch.seed_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_vld_r <= '0;
    end else if (wr_en) begin
      pool_vld_r[wr_addr] <= 1'b1;
    end
  end

  // two registered reads at draw accept
  always_ff @(posedge clk) begin
    if (draw_acc) begin
      rd_old_r  <= pool_mem[pos_r];
      rd_new_r  <= pool_mem[pos_inc];
      old_vld_r <= pool_vld_r[pos_r];
      new_vld_r <= pool_vld_r[pos_inc];
      bound_r   <= in_ch.range_bound;
      bad_r     <= (in_ch.range_bound == '0);
    end
  end

  assign old_word = old_vld_r ? rd_old_r : '0;
  assign new_word = new_vld_r ? rd_new_r : '0;
  assign mix_t    = new_word ^ (new_word << SHL_A);
  assign mixed    = mix_t ^ old_word ^ (mix_t >> SHR_B) ^ (old_word >> SHR_C);

  // golden-ratio multiply, one digit per cycle, top digit first
  assign digit_prod = {{DIGIT_W{1'b0}}, GOLDEN_MUL}
                    * {{WORD_W{1'b0}}, mul_op_r[WORD_W-1 -: DIGIT_W]};
  assign acc_nxt    = {acc_r[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                    + digit_prod[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (mix_go) begin
      mul_cnt_r <= '0;
    end else if (mul_run) begin
      mul_cnt_r <= mul_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_go) begin
      mul_op_r <= mixed;
      acc_r    <= '0;
    end else if (mul_run) begin
      mul_op_r <= {mul_op_r[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      acc_r    <= acc_nxt;
    end
  end

  xsr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (acc_nxt),
    .divisor   (bound_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_raw_r <= acc_r;
      out_val_r <= bad_r ? '0 : div_rem;
      out_bad_r <= bad_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.raw_word    = out_raw_r;
  assign out_ch.drawn_value = out_val_r;
  assign out_ch.bad_bound   = out_bad_r;

endmodule
`default_nettype wire
